// ----- sv/dfr_pkg.sv -----
// Shared types and constants for the dash frame receiver.
`default_nettype none
package dfr_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'h5A;
  localparam logic [7:0] HDR_SECOND = 8'hA5;
  localparam logic [7:0] CMD_STATUS = 8'h64;
  localparam logic [7:0] CMD_HALL   = 8'h65;

  localparam logic [7:0] THR_LOW  = 8'd40;
  localparam logic [7:0] THR_SPAN = 8'd157;
  localparam logic [7:0] BRK_LOW  = 8'd41;
  localparam logic [7:0] BRK_SPAN = 8'd140;

  localparam logic [7:0] MIN_HALL_LEN = 8'd3;
  localparam logic [2:0] INFO_LAST    = 3'd4;
  localparam logic [2:0] INFO_LEN     = 3'd0;
  localparam logic [2:0] INFO_CMD     = 3'd3;
  localparam logic [7:0] PAY_THR      = 8'd1;
  localparam logic [7:0] PAY_BRK      = 8'd2;

  // ceil(2^32 / span): floor(d * 2^16 / span) == (d * MUL) >> 16 for 8-bit d
  localparam logic [63:0] THR_MUL_FULL =
    ((64'd1 << 32) + 64'(THR_SPAN) - 64'd1) / 64'(THR_SPAN);
  localparam logic [63:0] BRK_MUL_FULL =
    ((64'd1 << 32) + 64'(BRK_SPAN) - 64'd1) / 64'(BRK_SPAN);
  localparam logic [24:0] THR_MUL = THR_MUL_FULL[24:0];
  localparam logic [24:0] BRK_MUL = BRK_MUL_FULL[24:0];

  localparam logic [1:0] ST_HALL   = 2'd0;
  localparam logic [1:0] ST_OTHER  = 2'd1;
  localparam logic [1:0] ST_BADSUM = 2'd2;

  typedef struct packed {
    logic [15:0] throttle_level;
    logic [15:0] brake_level;
    logic        brake_on;
  } dfr_level_t;

  typedef struct packed {
    logic [1:0]  frame_status;
    logic [7:0]  command_code;
    logic [7:0]  payload_length;
    logic [7:0]  raw_throttle;
    logic [7:0]  raw_brake;
    logic [15:0] throttle_level;
    logic [15:0] brake_level;
    logic        brake_on;
  } dfr_result_t;

endpackage
`default_nettype wire

// ----- sv/dfr_if.sv -----
// Valid/ready channel interfaces for received bytes and frame results.
`default_nettype none
interface dfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface dfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_status;
  logic [7:0]  command_code;
  logic [7:0]  payload_length;
  logic [7:0]  raw_throttle;
  logic [7:0]  raw_brake;
  logic [15:0] throttle_level;
  logic [15:0] brake_level;
  logic        brake_on;

  modport source (
    output valid, output frame_status, output command_code, output payload_length,
    output raw_throttle, output raw_brake, output throttle_level, output brake_level,
    output brake_on, input ready
  );
  modport sink (
    input valid, input frame_status, input command_code, input payload_length,
    input raw_throttle, input raw_brake, input throttle_level, input brake_level,
    input brake_on, output ready
  );
endinterface
`default_nettype wire

// ----- sv/dfr_scale.sv -----
// Hall level scaling: deadzone, reciprocal multiply to Q0.16, saturation.
`default_nettype none
module dfr_scale (
  input  wire logic [7:0]          raw_throttle,
  input  wire logic [7:0]          raw_brake,
  output dfr_pkg::dfr_level_t      level
);

  logic [7:0]  thr_d;
  logic [7:0]  brk_d;
  logic [32:0] thr_prod;
  logic [32:0] brk_prod;
  logic [16:0] thr_q;
  logic [16:0] brk_q;
  logic        thr_act;
  logic        brk_act;

  assign thr_act  = raw_throttle > dfr_pkg::THR_LOW;
  assign brk_act  = raw_brake > dfr_pkg::BRK_LOW;
  assign thr_d    = raw_throttle - dfr_pkg::THR_LOW;
  assign brk_d    = raw_brake - dfr_pkg::BRK_LOW;
  assign thr_prod = 33'(thr_d) * 33'(dfr_pkg::THR_MUL);
  assign brk_prod = 33'(brk_d) * 33'(dfr_pkg::BRK_MUL);
  assign thr_q    = thr_prod[32:16];
  assign brk_q    = brk_prod[32:16];

  always_comb begin
    level.throttle_level = 16'h0000;
    level.brake_level    = 16'h0000;
    level.brake_on       = brk_act;
    if (thr_act) begin
      level.throttle_level = thr_q[16] ? 16'hFFFF : thr_q[15:0];
    end
    if (brk_act) begin
      level.brake_level = brk_q[16] ? 16'hFFFF : brk_q[15:0];
    end
  end

endmodule
`default_nettype wire

// ----- sv/dfr_parser.sv -----
// Frame parser: header hunt, info/payload capture, running sum, checksum and decode hold.
`default_nettype none
module dfr_parser (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,
  input  wire logic [7:0]           rx_byte,
  input  wire dfr_pkg::dfr_level_t  level,
  output logic [7:0]                cap_throttle,
  output logic [7:0]                cap_brake,
  output logic                      last_byte,
  output dfr_pkg::dfr_result_t      result
);

  typedef enum logic [2:0] {
    PH_HUNT1   = 3'd0,
    PH_HUNT2   = 3'd1,
    PH_INFO    = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK   = 3'd4
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  info_cnt_r, info_cnt_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  pay_cnt_r, pay_cnt_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  chk_lo_r, chk_lo_nxt;
  logic        chk_cnt_r, chk_cnt_nxt;
  logic [7:0]  cap_thr_r, cap_thr_nxt;
  logic [7:0]  cap_brk_r, cap_brk_nxt;
  logic [7:0]  dec_thr_r, dec_thr_nxt;
  logic [7:0]  dec_brk_r, dec_brk_nxt;
  logic [15:0] thr_hold_r, thr_hold_nxt;
  logic [15:0] brk_hold_r, brk_hold_nxt;
  logic        brk_flag_r, brk_flag_nxt;

  logic [15:0] sum_add;
  logic [15:0] received;
  logic        sum_ok;
  logic        hall_cmd;
  logic [1:0]  status;
  logic [8:0]  pay_next;

  assign sum_add   = sum_r + 16'(rx_byte);
  assign received  = {rx_byte, chk_lo_r};
  assign sum_ok    = received == ~sum_r;
  assign hall_cmd  = (cmd_r == dfr_pkg::CMD_STATUS) || (cmd_r == dfr_pkg::CMD_HALL);
  assign pay_next  = {1'b0, pay_cnt_r} + 9'd1;
  assign last_byte = (phase_r == PH_CHECK) && chk_cnt_r;

  assign cap_throttle = cap_thr_r;
  assign cap_brake    = cap_brk_r;

  always_comb begin
    phase_nxt    = phase_r;
    info_cnt_nxt = info_cnt_r;
    len_nxt      = len_r;
    cmd_nxt      = cmd_r;
    pay_cnt_nxt  = pay_cnt_r;
    sum_nxt      = sum_r;
    chk_lo_nxt   = chk_lo_r;
    chk_cnt_nxt  = chk_cnt_r;
    cap_thr_nxt  = cap_thr_r;
    cap_brk_nxt  = cap_brk_r;
    dec_thr_nxt  = dec_thr_r;
    dec_brk_nxt  = dec_brk_r;
    thr_hold_nxt = thr_hold_r;
    brk_hold_nxt = brk_hold_r;
    brk_flag_nxt = brk_flag_r;
    status       = dfr_pkg::ST_BADSUM;
    unique case (phase_r)
      PH_HUNT2: begin
        if (rx_byte == dfr_pkg::HDR_SECOND) begin
          phase_nxt    = PH_INFO;
          info_cnt_nxt = 3'd0;
          sum_nxt      = 16'h0000;
        end else if (rx_byte != dfr_pkg::HDR_FIRST) begin
          phase_nxt = PH_HUNT1;
        end
      end
      PH_INFO: begin
        sum_nxt = sum_add;
        if (info_cnt_r == dfr_pkg::INFO_LEN) begin
          len_nxt = rx_byte;
        end else if (info_cnt_r == dfr_pkg::INFO_CMD) begin
          cmd_nxt = rx_byte;
        end
        info_cnt_nxt = info_cnt_r + 3'd1;
        if (info_cnt_r >= dfr_pkg::INFO_LAST) begin
          info_cnt_nxt = 3'd0;
          pay_cnt_nxt  = 8'd0;
          chk_cnt_nxt  = 1'b0;
          phase_nxt    = (len_r != 8'd0) ? PH_PAYLOAD : PH_CHECK;
        end
      end
      PH_PAYLOAD: begin
        sum_nxt = sum_add;
        if (pay_cnt_r == dfr_pkg::PAY_THR) begin
          cap_thr_nxt = rx_byte;
        end else if (pay_cnt_r == dfr_pkg::PAY_BRK) begin
          cap_brk_nxt = rx_byte;
        end
        pay_cnt_nxt = pay_next[7:0];
        if (pay_next >= {1'b0, len_r}) begin
          chk_cnt_nxt = 1'b0;
          phase_nxt   = PH_CHECK;
        end
      end
      PH_CHECK: begin
        if (!chk_cnt_r) begin
          chk_lo_nxt  = rx_byte;
          chk_cnt_nxt = 1'b1;
        end else begin
          chk_cnt_nxt = 1'b0;
          phase_nxt   = PH_HUNT1;
          if (sum_ok) begin
            if (hall_cmd) begin
              status = dfr_pkg::ST_HALL;
              if (len_r >= dfr_pkg::MIN_HALL_LEN) begin
                dec_thr_nxt  = cap_thr_r;
                dec_brk_nxt  = cap_brk_r;
                thr_hold_nxt = level.throttle_level;
                brk_hold_nxt = level.brake_level;
                brk_flag_nxt = level.brake_on;
              end
            end else begin
              status = dfr_pkg::ST_OTHER;
            end
          end
        end
      end
      default: begin
        phase_nxt = (rx_byte == dfr_pkg::HDR_FIRST) ? PH_HUNT2 : PH_HUNT1;
      end
    endcase
  end

  always_comb begin
    result.frame_status   = status;
    result.command_code   = cmd_r;
    result.payload_length = len_r;
    result.raw_throttle   = dec_thr_nxt;
    result.raw_brake      = dec_brk_nxt;
    result.throttle_level = thr_hold_nxt;
    result.brake_level    = brk_hold_nxt;
    result.brake_on       = brk_flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT1;
      info_cnt_r <= 3'd0;
      len_r      <= 8'd0;
      cmd_r      <= 8'd0;
      pay_cnt_r  <= 8'd0;
      sum_r      <= 16'h0000;
      chk_lo_r   <= 8'd0;
      chk_cnt_r  <= 1'b0;
      cap_thr_r  <= 8'd0;
      cap_brk_r  <= 8'd0;
      dec_thr_r  <= 8'd0;
      dec_brk_r  <= 8'd0;
      thr_hold_r <= 16'h0000;
      brk_hold_r <= 16'h0000;
      brk_flag_r <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      info_cnt_r <= info_cnt_nxt;
      len_r      <= len_nxt;
      cmd_r      <= cmd_nxt;
      pay_cnt_r  <= pay_cnt_nxt;
      sum_r      <= sum_nxt;
      chk_lo_r   <= chk_lo_nxt;
      chk_cnt_r  <= chk_cnt_nxt;
      cap_thr_r  <= cap_thr_nxt;
      cap_brk_r  <= cap_brk_nxt;
      dec_thr_r  <= dec_thr_nxt;
      dec_brk_r  <= dec_brk_nxt;
      thr_hold_r <= thr_hold_nxt;
      brk_hold_r <= brk_hold_nxt;
      brk_flag_r <= brk_flag_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/dash_frame_receiver.sv -----
// Dash frame receiver top level: input register, parser, scaler, result register.
//
// in_ch carries one received byte per item (rx_byte). Bytes are hunted for the
// header 5A A5, then five info bytes, the payload and a little-endian 16-bit
// sum-complement checksum follow. out_ch carries one item per completed frame:
// status (hall/status command, other command, checksum error), command, length
// and the held throttle/brake decode (raw levels, Q0.16 levels, brake flag).
// Throughput: one byte per cycle, set by the single parser pass per byte, except
// while a frame end waits behind an untaken result. A result reaches out_ch via
// the input register, where the parser evaluates the last checksum byte, and then
// the result register, which is loaded when that byte advances.
// A stalled out_ch holds its item; bytes that finish no frame keep flowing, and
// only a second frame end waiting behind an untaken result holds the input.
// Reset (rst_n low, synchronous) returns the parser to the header hunt, clears
// the held decode values and empties both registers.
`default_nettype none
module dash_frame_receiver (
  input wire logic  clk,
  input wire logic  rst_n,
  dfr_in_if.sink    in_ch,
  dfr_out_if.source out_ch
);

  logic                  in_vld_r;
  logic [7:0]            in_byte_r;
  logic                  out_vld_r;
  dfr_pkg::dfr_result_t  out_res_r;
  logic                  advance;
  logic                  last_byte;
  logic [7:0]            cap_throttle;
  logic [7:0]            cap_brake;
  dfr_pkg::dfr_level_t   level;
  dfr_pkg::dfr_result_t  result;

  assign advance     = in_vld_r && (!last_byte || !out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.rx_byte;
    end
  end

  dfr_scale u_scale (
    .raw_throttle (cap_throttle),
    .raw_brake    (cap_brake),
    .level        (level)
  );

  dfr_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .rx_byte      (in_byte_r),
    .level        (level),
    .cap_throttle (cap_throttle),
    .cap_brake    (cap_brake),
    .last_byte    (last_byte),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && last_byte) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last_byte) begin
      out_res_r <= result;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.frame_status   = out_res_r.frame_status;
  assign out_ch.command_code   = out_res_r.command_code;
  assign out_ch.payload_length = out_res_r.payload_length;
  assign out_ch.raw_throttle   = out_res_r.raw_throttle;
  assign out_ch.raw_brake      = out_res_r.raw_brake;
  assign out_ch.throttle_level = out_res_r.throttle_level;
  assign out_ch.brake_level    = out_res_r.brake_level;
  assign out_ch.brake_on       = out_res_r.brake_on;

  a_frame_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
    advance && last_byte |=> out_vld_r)
    else $error("frame end did not load a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> $stable(out_res_r))
    else $error("waiting result overwritten");

  a_brake_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_res_r.brake_on || (out_res_r.brake_level == 16'h0000)))
    else $error("brake level without brake flag");

  a_thr_deadzone: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_res_r.raw_throttle <= dfr_pkg::THR_LOW)
      |-> (out_res_r.throttle_level == 16'h0000))
    else $error("throttle level inside deadzone");

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Testbench for dash_frame_receiver: streamed byte frames checked against a built-in parser model.
`timescale 1ns / 100ps
module testbench;

  typedef enum logic [2:0] {
    SEEK_SYNC1, SEEK_SYNC2, TAKE_INFO, TAKE_PAYLOAD, TAKE_CHECK
  } parse_state_t;

  localparam int unsigned HOLD_LEN     = 250;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASE_BYTES  = 480;

  logic clk = 1'b0;
  logic rst_n;

  dfr_in_if  in_ch ();
  dfr_out_if out_ch ();

  dash_frame_receiver i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  logic [7:0]           byte_queue[$];
  dfr_pkg::dfr_result_t expected_frames[$];
  int unsigned queued_bytes = 0;
  int unsigned accepted_bytes = 0;
  int unsigned send_idle_pct = 36;
  int unsigned recv_idle_pct = 51;
  int unsigned errors = 0;
  int unsigned frames_checked = 0;
  int unsigned status_seen[3] = '{0, 0, 0};
  bit          in_fire = 1'b0;
  bit          out_fire = 1'b0;
  bit          hold_start = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_count = 0;
  int unsigned quiet_cycles = 0;

  // parser model state
  parse_state_t pstate = SEEK_SYNC1;
  logic [2:0]   info_idx = '0;
  logic [7:0]   len_reg = '0;
  logic [7:0]   cmd_reg = '0;
  logic [7:0]   pay_idx = '0;
  logic [15:0]  sum_acc = '0;
  logic [7:0]   chk_lo = '0;
  logic         chk_half = 1'b0;
  logic [7:0]   cap_thr = '0;
  logic [7:0]   cap_brk = '0;
  logic [7:0]   last_thr = '0;
  logic [7:0]   last_brk = '0;
  logic [15:0]  thr_level = '0;
  logic [15:0]  brk_level = '0;
  logic         brk_flag = 1'b0;

  function automatic logic [15:0] hall_fraction(logic [7:0] raw, logic [7:0] low,
                                                logic [7:0] span);
    logic [31:0] q;
    if (raw <= low) begin
      return 16'd0;
    end
    q = {8'd0, 8'(raw - low), 16'd0} / 32'(span);
    return (q > 32'hFFFF) ? 16'hFFFF : q[15:0];
  endfunction

  task automatic parse_byte(logic [7:0] b);
    logic [15:0] got;
    dfr_pkg::dfr_result_t r;
    case (pstate)
      SEEK_SYNC2: begin
        if (b == dfr_pkg::HDR_SECOND) begin
          pstate = TAKE_INFO;
          info_idx = '0;
          sum_acc = '0;
        end else if (b != dfr_pkg::HDR_FIRST) begin
          pstate = SEEK_SYNC1;
        end
      end
      TAKE_INFO: begin
        sum_acc += 16'(b);
        if (info_idx == dfr_pkg::INFO_LEN) begin
          len_reg = b;
        end else if (info_idx == dfr_pkg::INFO_CMD) begin
          cmd_reg = b;
        end
        if (info_idx == dfr_pkg::INFO_LAST) begin
          info_idx = '0;
          pay_idx = '0;
          chk_half = 1'b0;
          pstate = (len_reg != 0) ? TAKE_PAYLOAD : TAKE_CHECK;
        end else begin
          info_idx++;
        end
      end
      TAKE_PAYLOAD: begin
        sum_acc += 16'(b);
        if (pay_idx == dfr_pkg::PAY_THR) begin
          cap_thr = b;
        end else if (pay_idx == dfr_pkg::PAY_BRK) begin
          cap_brk = b;
        end
        pay_idx++;
        if (pay_idx >= len_reg) begin
          chk_half = 1'b0;
          pstate = TAKE_CHECK;
        end
      end
      TAKE_CHECK: begin
        if (!chk_half) begin
          chk_lo = b;
          chk_half = 1'b1;
        end else begin
          chk_half = 1'b0;
          pstate = SEEK_SYNC1;
          got = {b, chk_lo};
          if (got != ~sum_acc) begin
            r.frame_status = dfr_pkg::ST_BADSUM;
          end else if (cmd_reg == dfr_pkg::CMD_STATUS || cmd_reg == dfr_pkg::CMD_HALL) begin
            r.frame_status = dfr_pkg::ST_HALL;
            if (len_reg >= dfr_pkg::MIN_HALL_LEN) begin
              last_thr = cap_thr;
              last_brk = cap_brk;
              thr_level = hall_fraction(cap_thr, dfr_pkg::THR_LOW, dfr_pkg::THR_SPAN);
              brk_level = hall_fraction(cap_brk, dfr_pkg::BRK_LOW, dfr_pkg::BRK_SPAN);
              brk_flag = (cap_brk > dfr_pkg::BRK_LOW);
            end
          end else begin
            r.frame_status = dfr_pkg::ST_OTHER;
          end
          r.command_code = cmd_reg;
          r.payload_length = len_reg;
          r.raw_throttle = last_thr;
          r.raw_brake = last_brk;
          r.throttle_level = thr_level;
          r.brake_level = brk_level;
          r.brake_on = brk_flag;
          expected_frames.push_back(r);
        end
      end
      default: pstate = (b == dfr_pkg::HDR_FIRST) ? SEEK_SYNC2 : SEEK_SYNC1;
    endcase
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  task automatic offer(logic [7:0] b);
    byte_queue.push_back(b);
    queued_bytes++;
  endtask

  // keep < 0 sends the whole frame, otherwise only its first keep bytes
  task automatic queue_frame(logic [7:0] len, logic [7:0] cmd, logic [7:0] thr,
                             logic [7:0] brk, bit bad_sum, int keep);
    logic [7:0]  frame[$];
    logic [7:0]  pb;
    logic [15:0] total;
    logic [15:0] chk;
    frame.push_back(dfr_pkg::HDR_FIRST);
    frame.push_back(dfr_pkg::HDR_SECOND);
    frame.push_back(len);
    frame.push_back(8'($urandom));
    frame.push_back(8'($urandom));
    frame.push_back(cmd);
    frame.push_back(8'($urandom));
    for (int i = 0; i < int'(len); i++) begin
      pb = (i == 1) ? thr : (i == 2) ? brk : 8'($urandom);
      frame.push_back(pb);
    end
    total = '0;
    for (int i = 2; i < frame.size(); i++) begin
      total += 16'(frame[i]);
    end
    chk = ~total;
    if (bad_sum) begin
      chk ^= 16'(1) << $urandom_range(15);
    end
    frame.push_back(chk[7:0]);
    frame.push_back(chk[15:8]);
    for (int i = 0; i < frame.size() && (keep < 0 || i < keep); i++) begin
      offer(frame[i]);
    end
  endtask

  function automatic logic [7:0] pick_level();
    if ($urandom_range(99) < 35) begin
      case ($urandom_range(8))
        0: return 8'd0;
        1: return 8'd40;
        2: return 8'd41;
        3: return 8'd42;
        4: return 8'd180;
        5: return 8'd181;
        6: return 8'd196;
        7: return 8'd197;
        default: return 8'd255;
      endcase
    end
    return 8'($urandom);
  endfunction

  task automatic random_traffic(int unsigned goal);
    int unsigned pick;
    int unsigned n;
    logic [7:0]  len;
    logic [7:0]  cmd;
    while (queued_bytes < goal) begin
      pick = $urandom_range(99);
      n = $urandom_range(99);
      len = (n < 70) ? 8'($urandom_range(6)) :
            (n < 97) ? 8'($urandom_range(24, 7)) : 8'($urandom_range(120, 25));
      if ($urandom_range(99) < 65) begin
        cmd = $urandom_range(1) ? dfr_pkg::CMD_HALL : dfr_pkg::CMD_STATUS;
      end else begin
        cmd = 8'($urandom);
      end
      if (pick < 76) begin
        queue_frame(len, cmd, pick_level(), pick_level(), 1'b0, -1);
      end else if (pick < 86) begin
        queue_frame(len, cmd, pick_level(), pick_level(), 1'b1, -1);
      end else if (pick < 92) begin
        queue_frame(len, cmd, pick_level(), pick_level(), 1'b0, $urandom_range(8, 2));
      end else begin
        repeat ($urandom_range(4, 1)) begin
          n = $urandom_range(2);
          offer((n == 0) ? dfr_pkg::HDR_FIRST :
                (n == 1) ? dfr_pkg::HDR_SECOND : 8'($urandom));
        end
      end
    end
  endtask

  task automatic wait_idle();
    while (accepted_bytes < queued_bytes || expected_frames.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // byte driver
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_fire)) begin
      if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.rx_byte <= byte_queue.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result ready, with one long hold-off
  always @(negedge clk) begin
    if (hold_start && !hold_done) begin
      out_ch.ready <= 1'b0;
      hold_count++;
      if (hold_count == HOLD_LEN) begin
        hold_done = 1'b1;
      end
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor, scoreboard and watchdog
  always @(posedge clk) begin
    dfr_pkg::dfr_result_t want;
    in_fire = rst_n && in_ch.valid && in_ch.ready;
    out_fire = rst_n && out_ch.valid && out_ch.ready;
    if (out_fire) begin
      if (expected_frames.size() == 0) begin
        errors++;
        $display("%0t ns: result with none expected, status %0d cmd 0x%0h", $time,
                 out_ch.frame_status, out_ch.command_code);
      end else begin
        want = expected_frames.pop_front();
        check_field("frame_status", 16'(want.frame_status), 16'(out_ch.frame_status));
        check_field("command_code", 16'(want.command_code), 16'(out_ch.command_code));
        check_field("payload_length", 16'(want.payload_length),
                    16'(out_ch.payload_length));
        check_field("raw_throttle", 16'(want.raw_throttle), 16'(out_ch.raw_throttle));
        check_field("raw_brake", 16'(want.raw_brake), 16'(out_ch.raw_brake));
        check_field("throttle_level", want.throttle_level, out_ch.throttle_level);
        check_field("brake_level", want.brake_level, out_ch.brake_level);
        check_field("brake_on", 16'(want.brake_on), 16'(out_ch.brake_on));
        frames_checked++;
        status_seen[want.frame_status]++;
      end
    end
    if (in_fire) begin
      parse_byte(in_ch.rx_byte);
      accepted_bytes++;
    end
    if (!rst_n || in_fire || out_fire) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("dash_frame_receiver: mismatch");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = 8'h00;
    out_ch.ready = 1'b0;

    // directed: header hunt, level edges, short and empty frames, bad sums
    offer(8'h00);
    offer(8'hFF);
    offer(dfr_pkg::HDR_FIRST);
    offer(8'h13);
    offer(dfr_pkg::HDR_FIRST);
    queue_frame(8'd3, dfr_pkg::CMD_HALL, 8'd0, 8'd0, 1'b0, -1);
    queue_frame(8'd4, dfr_pkg::CMD_STATUS, 8'd40, 8'd41, 1'b0, -1);
    queue_frame(8'd3, dfr_pkg::CMD_HALL, 8'd41, 8'd42, 1'b0, -1);
    queue_frame(8'd5, dfr_pkg::CMD_STATUS, 8'd196, 8'd180, 1'b0, -1);
    queue_frame(8'd3, dfr_pkg::CMD_HALL, 8'd197, 8'd181, 1'b0, -1);
    queue_frame(8'd3, dfr_pkg::CMD_STATUS, 8'd255, 8'd255, 1'b0, -1);
    queue_frame(8'd3, dfr_pkg::CMD_HALL, 8'd100, 8'd100, 1'b1, -1);
    queue_frame(8'd0, dfr_pkg::CMD_HALL, 8'd0, 8'd0, 1'b0, -1);
    queue_frame(8'd1, dfr_pkg::CMD_STATUS, 8'd0, 8'd0, 1'b0, -1);
    queue_frame(8'd2, dfr_pkg::CMD_HALL, 8'd200, 8'd0, 1'b0, -1);
    queue_frame(8'd0, 8'h00, 8'd0, 8'd0, 1'b0, -1);
    queue_frame(8'd4, 8'hFF, 8'd90, 8'd90, 1'b0, -1);
    queue_frame(8'd255, dfr_pkg::CMD_HALL, 8'd90, 8'd120, 1'b0, -1);
    queue_frame(8'd6, dfr_pkg::CMD_HALL, 8'd1, 8'd2, 1'b0, 5);
    random_traffic(PHASE_BYTES);

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    wait_idle();

    send_idle_pct = 51;
    recv_idle_pct = 36;
    hold_start = 1'b1;
    random_traffic(2 * PHASE_BYTES);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_traffic(3 * PHASE_BYTES);
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("%0d bytes sent, %0d frames checked: %0d hall/status, %0d other, %0d bad sum",
             accepted_bytes, frames_checked, status_seen[dfr_pkg::ST_HALL],
             status_seen[dfr_pkg::ST_OTHER], status_seen[dfr_pkg::ST_BADSUM]);
    $display("three handshake mixes plus a %0d-cycle result hold-off, %0d errors",
             HOLD_LEN, errors);
    if (errors == 0) begin
      $display("dash_frame_receiver: match");
    end else begin
      $display("dash_frame_receiver: mismatch");
    end
    $finish;
  end

endmodule
